// ===== hdl/amdfs_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// amdfs_pkg
// Shared types and constants of the adjacency matrix depth-first engine.
// ---------------------------------------------------------------------------
package amdfs_pkg;

  localparam int CFG_DATA_W = 6;
  localparam int CFG_IDX_W  = 1;

  // no-edge marker before it is cut to the stored weight width
  localparam logic [15:0] NO_EDGE_RAW = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VERTEX_COUNT = 1'b0,
    REG_DIRECTED     = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    REQ_SET_LABEL = 2'd0,
    REQ_ADD_EDGE  = 2'd1,
    REQ_TRAVERSE  = 2'd2,
    REQ_CLEAR     = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [4:0]  vertex_slot;
    logic [7:0]  first_label;
    logic [7:0]  second_label;
    logic [15:0] edge_weight;
  } in_word_t;

  typedef struct packed {
    logic [4:0] visit_index;
    logic [7:0] visit_label;
    logic       last_result;
    status_t    status;
  } out_word_t;

  // datapath operations, one per cycle
  typedef enum logic [3:0] {
    DP_NOP,
    DP_SET_LABEL,
    DP_LOAD,
    DP_SRCH,
    DP_WR_FWD,
    DP_WR_REV,
    DP_CLR_INIT,
    DP_CLR,
    DP_TRAV_INIT,
    DP_ROOT,
    DP_SCAN,
    DP_FLUSH
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    logic    reply;
    status_t reply_status;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_end;
    logic srch_end;
    logic found_both;
    logic n_zero;
    logic root_end;
    logic root_seen;
    logic tree_end;
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== hdl/amdfs_dp.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// amdfs_dp
// Datapath: label table, weight matrix RAM, visited marks, walk stack,
// search and scan counters, result register.
// ---------------------------------------------------------------------------
module amdfs_dp #(
  parameter int MAX_VERTICES = 32,
  parameter int WEIGHT_BITS  = 16,
  localparam int ACT = (MAX_VERTICES < 32) ? MAX_VERTICES : 32,
  localparam int VW  = $clog2(ACT),
  localparam int CW  = VW + 1
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire amdfs_pkg::in_word_t in_data,
  input  wire logic [CW-1:0]       n,
  input  wire amdfs_pkg::dp_cmd_t  cmd,
  output amdfs_pkg::dp_sts_t       sts,
  output logic                     out_strobe,
  output amdfs_pkg::out_word_t     out_data
);
  import amdfs_pkg::*;

  localparam int MEM_AW    = 2 * VW;
  localparam int MEM_DEPTH = 1 << MEM_AW;
  localparam logic [31:0] NO_EDGE_FULL = 32'(NO_EDGE_RAW);
  localparam logic [WEIGHT_BITS-1:0] NO_EDGE = NO_EDGE_FULL[WEIGHT_BITS-1:0];

  logic [7:0]             label_r [ACT];
  logic [VW-1:0]          stk_v_r [ACT];
  logic [CW-1:0]          stk_n_r [ACT];
  logic [WEIGHT_BITS-1:0] mem     [MEM_DEPTH];
  logic [WEIGHT_BITS-1:0] rdata_r;

  logic [ACT-1:0]         visited_r, visited_nxt;
  logic [VW-1:0]          sp_r, sp_nxt;
  logic [MEM_AW-1:0]      clr_addr_r, clr_addr_nxt;
  logic [CW-1:0]          k_r, k_nxt, root_r, root_nxt, i_r, i_nxt;
  logic [VW-1:0]          a_r, a_nxt, b_r, b_nxt, v_r, v_nxt;
  logic [VW-1:0]          pend_j_r, pend_j_nxt, held_idx_r, held_idx_nxt;
  logic                   found_a_r, found_a_nxt, found_b_r, found_b_nxt;
  logic                   pend_r, pend_nxt, held_valid_r, held_valid_nxt;
  logic [7:0]             lab1_r, lab1_nxt, lab2_r, lab2_nxt;
  logic [7:0]             held_lab_r, held_lab_nxt;
  logic [WEIGHT_BITS-1:0] wt_r, wt_nxt;
  logic                   out_strobe_r, out_strobe_nxt;
  out_word_t              out_data_r, out_data_nxt;

  logic [31:0]            wt_full;
  logic [VW-1:0]          rd_idx, vis_idx;
  logic [7:0]             rd_lab;
  logic                   hit, row_end, vis_en, push_en, lab_we;
  logic                   mem_we, mem_re;
  logic [MEM_AW-1:0]      mem_waddr, mem_raddr;
  logic [WEIGHT_BITS-1:0] mem_wdata;

  assign wt_full = 32'(in_data.edge_weight);

  // one read port on the label table, steered by the operation
  always_comb begin
    case (cmd.op)
      DP_SRCH: rd_idx = k_r[VW-1:0];
      DP_ROOT: rd_idx = root_r[VW-1:0];
      default: rd_idx = pend_j_r;
    endcase
  end
  assign rd_lab = label_r[rd_idx];

  assign hit     = pend_r && (rdata_r != NO_EDGE) && !visited_r[pend_j_r];
  assign row_end = !hit && (i_r >= n);

  assign sts.clr_end    = &clr_addr_r;
  assign sts.srch_end   = (k_r >= n);
  assign sts.found_both = found_a_r && found_b_r;
  assign sts.n_zero     = (n == '0);
  assign sts.root_end   = (root_r >= n);
  assign sts.root_seen  = visited_r[root_r[VW-1:0]];
  assign sts.tree_end   = row_end && (sp_r == '0);

  always_comb begin
    visited_nxt    = visited_r;
    sp_nxt         = sp_r;
    clr_addr_nxt   = clr_addr_r;
    k_nxt          = k_r;
    root_nxt       = root_r;
    i_nxt          = i_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    v_nxt          = v_r;
    pend_j_nxt     = pend_j_r;
    found_a_nxt    = found_a_r;
    found_b_nxt    = found_b_r;
    pend_nxt       = 1'b0;
    lab1_nxt       = lab1_r;
    lab2_nxt       = lab2_r;
    wt_nxt         = wt_r;
    vis_en         = 1'b0;
    vis_idx        = rd_idx;
    push_en        = 1'b0;
    lab_we         = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_waddr      = clr_addr_r;
    mem_raddr      = {v_r, i_r[VW-1:0]};
    mem_wdata      = NO_EDGE;

    case (cmd.op)
      DP_SET_LABEL: begin
        lab_we = ({1'b0, in_data.vertex_slot} < 6'(ACT));
      end
      DP_LOAD: begin
        lab1_nxt    = in_data.first_label;
        lab2_nxt    = in_data.second_label;
        wt_nxt      = wt_full[WEIGHT_BITS-1:0];
        k_nxt       = '0;
        found_a_nxt = 1'b0;
        found_b_nxt = 1'b0;
      end
      DP_SRCH: begin
        if (!found_a_r && rd_lab == lab1_r) begin
          found_a_nxt = 1'b1;
          a_nxt       = k_r[VW-1:0];
        end
        if (!found_b_r && rd_lab == lab2_r) begin
          found_b_nxt = 1'b1;
          b_nxt       = k_r[VW-1:0];
        end
        k_nxt = k_r + CW'(1);
      end
      DP_WR_FWD: begin
        mem_we    = 1'b1;
        mem_waddr = {a_r, b_r};
        mem_wdata = wt_r;
      end
      DP_WR_REV: begin
        mem_we    = 1'b1;
        mem_waddr = {b_r, a_r};
        mem_wdata = wt_r;
      end
      DP_CLR_INIT: begin
        clr_addr_nxt = '0;
      end
      DP_CLR: begin
        mem_we       = 1'b1;
        clr_addr_nxt = clr_addr_r + MEM_AW'(1);
      end
      DP_TRAV_INIT: begin
        visited_nxt = '0;
        root_nxt    = '0;
      end
      DP_ROOT: begin
        if (sts.root_seen) begin
          root_nxt = root_r + CW'(1);
        end else begin
          vis_en               = 1'b1;
          visited_nxt[rd_idx]  = 1'b1;
          v_nxt                = rd_idx;
          i_nxt                = '0;
          sp_nxt               = '0;
        end
      end
      DP_SCAN: begin
        if (hit) begin
          // enter the neighbour, save where this row resumes
          vis_en                = 1'b1;
          visited_nxt[pend_j_r] = 1'b1;
          push_en               = 1'b1;
          sp_nxt                = sp_r + VW'(1);
          v_nxt                 = pend_j_r;
          i_nxt                 = '0;
        end else if (row_end) begin
          if (sp_r == '0) begin
            root_nxt = root_r + CW'(1);
          end else begin
            v_nxt  = stk_v_r[sp_r - VW'(1)];
            i_nxt  = stk_n_r[sp_r - VW'(1)];
            sp_nxt = sp_r - VW'(1);
          end
        end else begin
          mem_re     = 1'b1;
          pend_nxt   = 1'b1;
          pend_j_nxt = i_r[VW-1:0];
          i_nxt      = i_r + CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // one-deep hold so that the final visit can carry the last flag
  always_comb begin
    held_valid_nxt = held_valid_r;
    held_idx_nxt   = held_idx_r;
    held_lab_nxt   = held_lab_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;
    if (cmd.op == DP_TRAV_INIT) begin
      held_valid_nxt = 1'b0;
    end
    if (vis_en) begin
      held_valid_nxt = 1'b1;
      held_idx_nxt   = vis_idx;
      held_lab_nxt   = rd_lab;
    end
    if (cmd.reply) begin
      out_strobe_nxt           = 1'b1;
      out_data_nxt.visit_index = '0;
      out_data_nxt.visit_label = '0;
      out_data_nxt.last_result = 1'b1;
      out_data_nxt.status      = cmd.reply_status;
    end else if (cmd.op == DP_FLUSH) begin
      out_strobe_nxt           = 1'b1;
      out_data_nxt.visit_index = 5'(held_idx_r);
      out_data_nxt.visit_label = held_lab_r;
      out_data_nxt.last_result = 1'b1;
      out_data_nxt.status      = ST_OK;
    end else if (vis_en && held_valid_r) begin
      out_strobe_nxt           = 1'b1;
      out_data_nxt.visit_index = 5'(held_idx_r);
      out_data_nxt.visit_label = held_lab_r;
      out_data_nxt.last_result = 1'b0;
      out_data_nxt.status      = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      visited_r    <= '0;
      sp_r         <= '0;
      clr_addr_r   <= '0;
      k_r          <= '0;
      root_r       <= '0;
      i_r          <= '0;
      found_a_r    <= 1'b0;
      found_b_r    <= 1'b0;
      pend_r       <= 1'b0;
      held_valid_r <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      visited_r    <= visited_nxt;
      sp_r         <= sp_nxt;
      clr_addr_r   <= clr_addr_nxt;
      k_r          <= k_nxt;
      root_r       <= root_nxt;
      i_r          <= i_nxt;
      found_a_r    <= found_a_nxt;
      found_b_r    <= found_b_nxt;
      pend_r       <= pend_nxt;
      held_valid_r <= held_valid_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    v_r        <= v_nxt;
    pend_j_r   <= pend_j_nxt;
    held_idx_r <= held_idx_nxt;
    held_lab_r <= held_lab_nxt;
    lab1_r     <= lab1_nxt;
    lab2_r     <= lab2_nxt;
    wt_r       <= wt_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 0; t < ACT; t++) begin
        label_r[t] <= '0;
      end
    end else if (lab_we) begin
      label_r[in_data.vertex_slot[VW-1:0]] <= in_data.first_label;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      stk_v_r[sp_r] <= v_r;
      stk_n_r[sp_r] <= {1'b0, pend_j_r} + CW'(1);
    end
  end

  // weight matrix, single port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  a_reply_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.reply |=> (out_strobe_r && out_data_r.last_result))
    else $error("reply not delivered as a final word");

  a_write_found: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == DP_WR_FWD || cmd.op == DP_WR_REV) |-> (found_a_r && found_b_r))
    else $error("matrix write without both endpoints");

  a_mid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && !out_data_r.last_result) |-> (out_data_r.status == ST_OK))
    else $error("non-final word carries an error status");

  a_stack_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == DP_SCAN && hit) |-> (sp_r != VW'(ACT - 1)))
    else $error("walk stack overflow");

endmodule
`default_nettype wire

// ===== hdl/amdfs_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// amdfs_ctrl
// Request sequencer: decodes accepted words and steps the datapath.
// ---------------------------------------------------------------------------
module amdfs_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [1:0]         req_type,
  input  wire logic               directed,
  input  wire amdfs_pkg::dp_sts_t sts,
  output logic                    busy,
  output amdfs_pkg::dp_cmd_t      cmd
);
  import amdfs_pkg::*;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_SRCH,
    S_WR_FWD,
    S_WR_REV,
    S_ROOT,
    S_SCAN
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;
  logic   clr_reply_r, clr_reply_nxt;

  always_comb begin
    state_nxt        = state_r;
    clr_reply_nxt    = clr_reply_r;
    cmd.op           = DP_NOP;
    cmd.reply        = 1'b0;
    cmd.reply_status = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (req_t'(req_type))
            REQ_SET_LABEL: begin
              cmd.op    = DP_SET_LABEL;
              cmd.reply = 1'b1;
            end
            REQ_ADD_EDGE: begin
              cmd.op    = DP_LOAD;
              state_nxt = S_SRCH;
            end
            REQ_TRAVERSE: begin
              cmd.op = DP_TRAV_INIT;
              if (sts.n_zero) begin
                cmd.reply        = 1'b1;
                cmd.reply_status = ST_EMPTY;
              end else begin
                state_nxt = S_ROOT;
              end
            end
            default: begin
              cmd.op        = DP_CLR_INIT;
              clr_reply_nxt = 1'b1;
              state_nxt     = S_CLR;
            end
          endcase
        end
      end
      S_SRCH: begin
        if (!sts.srch_end) begin
          cmd.op = DP_SRCH;
        end else if (sts.found_both) begin
          state_nxt = S_WR_FWD;
        end else begin
          cmd.reply        = 1'b1;
          cmd.reply_status = ST_NOT_FOUND;
          state_nxt        = S_IDLE;
        end
      end
      S_WR_FWD: begin
        cmd.op = DP_WR_FWD;
        if (directed) begin
          cmd.reply = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_WR_REV;
        end
      end
      S_WR_REV: begin
        cmd.op    = DP_WR_REV;
        cmd.reply = 1'b1;
        state_nxt = S_IDLE;
      end
      S_CLR: begin
        cmd.op = DP_CLR;
        if (sts.clr_end) begin
          cmd.reply     = clr_reply_r;
          clr_reply_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      S_ROOT: begin
        if (sts.root_end) begin
          cmd.op    = DP_FLUSH;
          state_nxt = S_IDLE;
        end else begin
          cmd.op = DP_ROOT;
          if (!sts.root_seen) begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.op = DP_SCAN;
        if (sts.tree_end) begin
          state_nxt = S_ROOT;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    busy_nxt = (state_nxt != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      busy_r      <= 1'b1;
      clr_reply_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      clr_reply_r <= clr_reply_nxt;
    end
  end

  assign busy = busy_r;

endmodule
`default_nettype wire

// ===== hdl/adjacency_matrix_dfs_engine.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// adjacency_matrix_dfs_engine
// Labelled graph in a weight matrix RAM with depth-first traversal.
// ---------------------------------------------------------------------------
//  channel   handshake            word
//  --------  -------------------  ------------------------------------------
//  in        start & !busy        in_data  : req, slot, labels, weight
//  out       out_strobe (1 cycle) out_data : index, label, last, status
//  cfg       cfg_we               cfg_index, cfg_wdata (no read-back)
//
//  Steps: set label answers on acceptance; add edge scans the labels of n
//  vertices, takes a decision, then makes one matrix write directed or two
//  undirected, or answers ST_NOT_FOUND at the decision with a missing label;
//  clear writes one RAM entry per cycle over all 2^(2*VW) entries; traversal
//  time is set by the single RAM read port that reads each matrix row once,
//  plus a step per root index, per push and per row end.
//  Reset: a clearing pass over all 2^(2*VW) entries (1024 at the defaults)
//  fills the matrix with the no-edge marker; busy is high meanwhile, cfg
//  writes are taken. Results are never held off: each word is on out_data
//  for exactly the one cycle that out_strobe marks. One request at a time.
// ---------------------------------------------------------------------------
module adjacency_matrix_dfs_engine #(
  parameter int MAX_VERTICES = 32,
  parameter int WEIGHT_BITS  = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire amdfs_pkg::in_word_t                   in_data,
  output logic                                       out_strobe,
  output amdfs_pkg::out_word_t                       out_data,
  input  wire logic                                  cfg_we,
  input  wire logic [amdfs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [amdfs_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import amdfs_pkg::*;

  // vertices that label search and traversal can ever reach
  localparam int ACT = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;
  localparam int VW  = $clog2(ACT);
  localparam int CW  = VW + 1;
  localparam logic [CFG_DATA_W-1:0] ACT_CNT = CFG_DATA_W'(ACT);

  logic [CFG_DATA_W-1:0] vertex_count_r, vertex_count_nxt;
  logic                  directed_r, directed_nxt;
  logic [CFG_DATA_W-1:0] n_sat;
  logic [CW-1:0]         n;
  dp_cmd_t               cmd;
  dp_sts_t               sts;

  // config registers
  always_comb begin
    vertex_count_nxt = vertex_count_r;
    directed_nxt     = directed_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_VERTEX_COUNT: vertex_count_nxt = cfg_wdata;
        REG_DIRECTED:     directed_nxt     = cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= '0;
      directed_r     <= 1'b0;
    end else begin
      vertex_count_r <= vertex_count_nxt;
      directed_r     <= directed_nxt;
    end
  end

  // vertex count saturates at the reachable size
  assign n_sat = (vertex_count_r > ACT_CNT) ? ACT_CNT : vertex_count_r;
  assign n     = n_sat[CW-1:0];

  amdfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req_type (in_data.req_type),
    .directed (directed_r),
    .sts      (sts),
    .busy     (busy),
    .cmd      (cmd)
  );

  amdfs_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .n          (n),
    .cmd        (cmd),
    .sts        (sts),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire

// ===== verif/adjacency_matrix_dfs_engine_test.sv =====
// ---------------------------------------------------------------------------
// adjacency_matrix_dfs_engine_test
// Self-checking bench for the labelled-graph depth-first engine. A local
// graph model (label table, weight matrix, vertex count, directed flag)
// predicts every output word. Directed cases run first, then random phases
// of well-formed edge sets. Each phase reprograms the configuration while
// the engine is idle.
// ---------------------------------------------------------------------------
module adjacency_matrix_dfs_engine_test;
  import amdfs_pkg::*;

  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int RANDOM_ITEMS = 140;

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 start      = 1'b0;
  in_word_t             in_data    = '0;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                 busy;
  logic                 out_strobe;
  out_word_t            out_data;

  adjacency_matrix_dfs_engine uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // local copy of the graph held by the engine
  logic [7:0]  vertex_labels [32];
  logic [15:0] edge_weights [32][32];
  logic [5:0]  vertex_count_r = '0;
  logic        directed_r     = 1'b0;

  out_word_t expected_words [$];
  out_word_t head_word;
  int        mismatches  = 0;
  int        cycle_count = 0;
  int        burst_left  = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop, well beyond the slowest legal run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("mismatch @%0d: %s", cycle_count, msg);
  endtask

  // -------------------------------------------------------------------------
  // Graph model
  // -------------------------------------------------------------------------
  // counts above 32 saturate
  function automatic int active_vertices();
    return (vertex_count_r > 6'd32) ? 32 : int'(vertex_count_r);
  endfunction

  // lowest in-use slot carrying the label, -1 if absent
  function automatic int find_vertex(input logic [7:0] lab);
    int n;
    n = active_vertices();
    for (int k = 0; k < n; k++)
      if (vertex_labels[k] == lab) return k;
    return -1;
  endfunction

  function automatic out_word_t make_result(input logic [4:0] idx, input logic [7:0] lab,
                                            input logic last, input status_t st);
    out_word_t r;
    r.visit_index = idx;
    r.visit_label = lab;
    r.last_result = last;
    r.status      = st;
    return r;
  endfunction

  function automatic in_word_t make_word(input req_t req, input logic [4:0] slot,
                                         input logic [7:0] lab_a, input logic [7:0] lab_b,
                                         input logic [15:0] weight);
    in_word_t w;
    w.req_type     = req;
    w.vertex_slot  = slot;
    w.first_label  = lab_a;
    w.second_label = lab_b;
    w.edge_weight  = weight;
    return w;
  endfunction

  task automatic reset_graph();
    foreach (vertex_labels[k]) vertex_labels[k] = '0;
    foreach (edge_weights[r, c]) edge_weights[r][c] = NO_EDGE_RAW;
  endtask

  // Depth-first visit order: roots by index, neighbours ascending, a
  // neighbour entered only when not yet seen. Last visit carries the flag.
  task automatic predict_walk();
    bit         seen [32];
    logic [4:0] stack_v [32];
    int         stack_next [32];
    out_word_t  visits [$];
    int         n, depth, v, j, root;
    bit         pushed;
    n = active_vertices();
    if (n == 0) begin
      expected_words.push_back(make_result('0, '0, 1'b1, ST_EMPTY));
      return;
    end
    foreach (seen[k]) seen[k] = 1'b0;
    for (root = 0; root < n; root++) begin
      if (!seen[root]) begin
        seen[root] = 1'b1;
        visits.push_back(make_result(5'(root), vertex_labels[root], 1'b0, ST_OK));
        stack_v[0]    = 5'(root);
        stack_next[0] = 0;
        depth         = 1;
        while (depth > 0) begin
          v      = int'(stack_v[depth-1]);
          j      = stack_next[depth-1];
          pushed = 1'b0;
          while (j < n && !pushed) begin
            if (edge_weights[v][j] != NO_EDGE_RAW && !seen[j]) begin
              stack_next[depth-1] = j + 1;
              seen[j] = 1'b1;
              visits.push_back(make_result(5'(j), vertex_labels[j], 1'b0, ST_OK));
              stack_v[depth]    = 5'(j);
              stack_next[depth] = 0;
              depth++;
              pushed = 1'b1;
            end
            j++;
          end
          if (!pushed) depth--;
        end
      end
    end
    visits[visits.size()-1].last_result = 1'b1;
    foreach (visits[k]) expected_words.push_back(visits[k]);
  endtask

  task automatic predict_word(input in_word_t w);
    int a, b;
    case (req_t'(w.req_type))
      REQ_SET_LABEL: begin
        vertex_labels[w.vertex_slot] = w.first_label;
        expected_words.push_back(make_result('0, '0, 1'b1, ST_OK));
      end
      REQ_ADD_EDGE: begin
        a = find_vertex(w.first_label);
        b = find_vertex(w.second_label);
        if (a < 0 || b < 0) begin
          expected_words.push_back(make_result('0, '0, 1'b1, ST_NOT_FOUND));
        end else begin
          edge_weights[a][b] = w.edge_weight;
          if (!directed_r) edge_weights[b][a] = w.edge_weight;
          expected_words.push_back(make_result('0, '0, 1'b1, ST_OK));
        end
      end
      REQ_CLEAR: begin
        foreach (edge_weights[r, c]) edge_weights[r][c] = NO_EDGE_RAW;
        expected_words.push_back(make_result('0, '0, 1'b1, ST_OK));
      end
      default: predict_walk();
    endcase
  endtask

  // -------------------------------------------------------------------------
  // Driving
  // -------------------------------------------------------------------------
  // start stays high across a burst; a gap of random length lowers it
  task automatic send_word(input in_word_t w);
    start   <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy !== 1'b0);
    predict_word(w);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? int'($urandom_range(10, 30))
                                               : int'($urandom_range(0, 4));
    end
  endtask

  // every expected word in and the engine back to idle
  task automatic wait_idle();
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // both registers, back to back, only while idle
  task automatic program_graph(input int unsigned count, input bit dir);
    cfg_we    <= 1'b1;
    cfg_index <= REG_VERTEX_COUNT;
    cfg_wdata <= count[CFG_DATA_W-1:0];
    @(posedge clk);
    vertex_count_r = count[5:0];
    cfg_index <= REG_DIRECTED;
    cfg_wdata <= {{(CFG_DATA_W-1){1'b0}}, dir};
    @(posedge clk);
    directed_r = dir;
    cfg_we <= 1'b0;
  endtask

  // -------------------------------------------------------------------------
  // Output checker: every strobed word against the oldest prediction
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_strobe !== 1'b0) begin
      if (expected_words.size() == 0) begin
        flag_mismatch($sformatf("word %h with nothing expected", out_data));
      end else begin
        head_word = expected_words.pop_front();
        if (out_data.visit_index !== head_word.visit_index)
          flag_mismatch($sformatf("visit_index %0d, want %0d",
                                  out_data.visit_index, head_word.visit_index));
        if (out_data.visit_label !== head_word.visit_label)
          flag_mismatch($sformatf("visit_label %h, want %h",
                                  out_data.visit_label, head_word.visit_label));
        if (out_data.last_result !== head_word.last_result)
          flag_mismatch($sformatf("last_result %b, want %b",
                                  out_data.last_result, head_word.last_result));
        if (out_data.status !== head_word.status)
          flag_mismatch($sformatf("status %0d, want %0d",
                                  out_data.status, head_word.status));
      end
    end
  end

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------
  // reset configuration: no vertices in use
  task automatic test_reset_state();
    send_word(make_word(REQ_TRAVERSE, 5'd0, 8'h00, 8'h00, 16'h0000));
    send_word(make_word(REQ_ADD_EDGE, 5'd0, 8'h00, 8'h00, 16'h0001));
    send_word(make_word(REQ_SET_LABEL, 5'd31, 8'hFF, 8'h00, 16'hFFFF));
    send_word(make_word(REQ_CLEAR, 5'd0, 8'h00, 8'h00, 16'h0000));
    wait_idle();
  endtask

  // four vertices, directed; missing labels, duplicate labels, removal
  task automatic test_directed_edges();
    program_graph(4, 1'b1);
    send_word(make_word(REQ_SET_LABEL, 5'd1, 8'hFF, 8'h00, 16'h0000));
    send_word(make_word(REQ_SET_LABEL, 5'd2, 8'h5A, 8'h00, 16'h0000));
    send_word(make_word(REQ_SET_LABEL, 5'd3, 8'hA5, 8'h00, 16'h0000));
    send_word(make_word(REQ_ADD_EDGE, 5'd0, 8'h00, 8'hFF, 16'h0000));
    send_word(make_word(REQ_ADD_EDGE, 5'd0, 8'hFF, 8'h5A, 16'hFFFE));
    send_word(make_word(REQ_ADD_EDGE, 5'd0, 8'hA5, 8'h5A, 16'h1234));
    send_word(make_word(REQ_ADD_EDGE, 5'd0, 8'h11, 8'h5A, 16'h0010));
    send_word(make_word(REQ_ADD_EDGE, 5'd0, 8'h5A, 8'h22, 16'h0010));
    send_word(make_word(REQ_TRAVERSE, 5'd0, 8'h00, 8'h00, 16'h0000));
    // no-edge weight removes 0 -> 1
    send_word(make_word(REQ_ADD_EDGE, 5'd0, 8'h00, 8'hFF, 16'hFFFF));
    // slot 3 duplicates the label of slot 1: the lower slot is used
    send_word(make_word(REQ_SET_LABEL, 5'd3, 8'hFF, 8'h00, 16'h0000));
    send_word(make_word(REQ_ADD_EDGE, 5'd0, 8'hFF, 8'h00, 16'h8000));
    send_word(make_word(REQ_TRAVERSE, 5'd0, 8'h00, 8'h00, 16'h0000));
    wait_idle();
  endtask

  // full-size graph, undirected, saturated count, clear keeps labels
  task automatic test_full_graph();
    program_graph(63, 1'b0);
    send_word(make_word(REQ_ADD_EDGE, 5'd0, 8'h5A, 8'h00, 16'h7FFF));
    send_word(make_word(REQ_TRAVERSE, 5'd0, 8'h00, 8'h00, 16'h0000));
    send_word(make_word(REQ_CLEAR, 5'd0, 8'h00, 8'h00, 16'h0000));
    send_word(make_word(REQ_TRAVERSE, 5'd0, 8'h00, 8'h00, 16'h0000));
    wait_idle();
    program_graph(32, 1'b0);
    send_word(make_word(REQ_ADD_EDGE, 5'd0, 8'hA5, 8'hFF, 16'h0001));
    send_word(make_word(REQ_TRAVERSE, 5'd0, 8'h00, 8'h00, 16'h0000));
    wait_idle();
  endtask

  // mostly edges between labels in use, some strays, label writes, walks and clears
  function automatic in_word_t random_request(input int n);
    in_word_t w;
    int       pick;
    w.vertex_slot  = 5'($urandom_range(0, 31));
    w.first_label  = 8'($urandom_range(0, 255));
    w.second_label = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 15))
      0:       w.edge_weight = NO_EDGE_RAW;
      1:       w.edge_weight = '0;
      default: w.edge_weight = 16'($urandom_range(0, 65535));
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      w.req_type = REQ_SET_LABEL;
      if (n > 0 && $urandom_range(0, 3) != 0) w.vertex_slot = 5'($urandom_range(0, n - 1));
    end else if (pick < 72) begin
      w.req_type = REQ_ADD_EDGE;
      if (n > 0 && $urandom_range(0, 9) != 0) begin
        w.first_label  = vertex_labels[$urandom_range(0, n - 1)];
        w.second_label = vertex_labels[$urandom_range(0, n - 1)];
      end
    end else if (pick < 95) begin
      w.req_type = REQ_TRAVERSE;
    end else begin
      w.req_type = REQ_CLEAR;
    end
    return w;
  endfunction

  task automatic test_random_graphs();
    int unsigned count;
    int          n, sent, phase_items, slots;
    logic [7:0]  lab;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       count = 0;
        1:       count = 32;
        2:       count = 63;
        3:       count = $urandom_range(13, 63);
        default: count = $urandom_range(2, 12);
      endcase
      program_graph(count, 1'($urandom_range(0, 1)));
      n = active_vertices();
      // labels first; a narrow pool now and then forces duplicates
      slots = (n <= 12) ? n : 8;
      for (int k = 0; k < slots; k++) begin
        lab = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
        send_word(make_word(REQ_SET_LABEL, (n <= 12) ? 5'(k) : 5'($urandom_range(0, n - 1)),
                            lab, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535))));
        sent++;
      end
      phase_items = $urandom_range(15, 30);
      repeat (phase_items) begin
        send_word(random_request(n));
        sent++;
      end
      send_word(make_word(REQ_TRAVERSE, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535))));
      sent++;
      wait_idle();
    end
  endtask

  // -------------------------------------------------------------------------
  // Sequence
  // -------------------------------------------------------------------------
  initial begin
    reset_graph();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // engine clears its matrix after reset; busy holds the first word off
    test_reset_state();
    test_directed_edges();
    test_full_graph();
    test_random_graphs();
    wait_idle();
    repeat (40) @(posedge clk);
    if (expected_words.size() != 0)
      flag_mismatch($sformatf("%0d words never arrived", expected_words.size()));
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== adjacency_matrix_dfs_engine.f =====
hdl/amdfs_pkg.sv
hdl/amdfs_dp.sv
hdl/amdfs_ctrl.sv
hdl/adjacency_matrix_dfs_engine.sv
verif/adjacency_matrix_dfs_engine_test.sv
